FILE: design/scsc_pkg.sv
// Package for the sprite column silhouette clip block.
// Holds opcodes, silhouette kinds, the front-to-back command type and FSM state types.
// No dependencies.
`default_nettype none

package scsc_pkg;

  // Input opcodes
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_HEADER = 2'd1;
  localparam logic [1:0] OP_COLUMN = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Silhouette kinds that change an opening
  localparam logic [2:0] KIND_TOP    = 3'd1;
  localparam logic [2:0] KIND_BOTTOM = 3'd2;
  localparam logic [2:0] KIND_BOTH   = 3'd3;
  localparam logic [2:0] KIND_SOLID  = 3'd4;

  // Reset value of the top half of an opening
  localparam logic [7:0] OPEN_TOP_DEFAULT = 8'h00;

  // Command queue depth
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_CLIP,
    CMD_READ
  } cmd_op_t;

  // One command from the front to the back
  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] first;
    logic [7:0] last;
    logic [2:0] kind;
    logic [7:0] tsil;
    logic [7:0] bsil;
    logic       force_default;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HDR_MUL,
    F_HDR_CMP
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EXEC
  } back_state_t;

endpackage

`default_nettype wire

FILE: design/scsc_if.sv
// Channel interfaces for the sprite column silhouette clip block.
// scsc_in_if carries input items, scsc_out_if carries opening results. No dependencies.
`default_nettype none

interface scsc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [7:0]         first_x;
  logic [7:0]         last_x;
  logic signed [31:0] scale_a;
  logic signed [31:0] scale_b;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic [2:0]         sil_kind;
  logic [7:0]         top_sil;
  logic [7:0]         bottom_sil;

  modport source (
    output valid, opcode, first_x, last_x, scale_a, scale_b, point_x, point_y,
           end_x, end_y, sil_kind, top_sil, bottom_sil,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_x, last_x, scale_a, scale_b, point_x, point_y,
           end_x, end_y, sil_kind, top_sil, bottom_sil,
    output ready
  );
endinterface

interface scsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] open_top;
  logic [7:0] open_bottom;

  modport source (output valid, open_top, open_bottom, input ready);
  modport sink (input valid, open_top, open_bottom, output ready);
endinterface

`default_nettype wire

FILE: design/sprite_column_silhouette_clip.sv
// Top level of the sprite column silhouette clip block.
// Connects scsc_front, scsc_cmd_fifo and scsc_back; uses scsc_pkg and the channel interfaces.
//
// Usage: items arrive on req (valid/ready); an item is a transaction at a clock edge
// with valid and ready high. A begin item stores the sprite and resets its columns,
// header items qualify one wall, column items clip one column, read items return one
// opening on rsp (valid/ready). Only read items produce a result.
// Rate: the front takes one item a cycle while the queue has room, except that a wall
// header holds it through difference capture, multiply and compare. The back end takes
// a begin in its idle state and a column or read as a store read, then an update or result,
// set by the single-port read-modify-write of the opening store. A 4-entry command queue
// parts the two, so each stalls on its own.
// Path: a read passes the command queue, the store read register and then the output
// register before its result is valid on rsp.
// Reset: synchronous, active high; every opening reads top 0, bottom SCREEN_HEIGHT at
// once (per-column valid bits), no clearing pass.
// Stall: while rsp is stalled the result is held; further items fill the queue, then
// req.ready drops.
`default_nettype none

module sprite_column_silhouette_clip import scsc_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 224
) (
  input  wire logic  clk,
  input  wire logic  rst,
  scsc_in_if.sink    req,
  scsc_out_if.source rsp
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_cmd, q_head;

  scsc_front #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  scsc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  scsc_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_head  (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

FILE: design/scsc_front.sv
// Front end: accepts items, keeps sprite and wall state, runs the wall header test
// and queues memory commands for the back end. Depends on scsc_pkg and scsc_in_if.
`default_nettype none

module scsc_front import scsc_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = 256
) (
  input  wire logic  clk,
  input  wire logic  rst,
  scsc_in_if.sink    req,
  input  wire logic  q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  front_state_t state, state_next;

  // Sprite and wall state
  logic [7:0]         sprite_first, sprite_last;
  logic signed [31:0] sprite_scale;
  logic [31:0]        sprite_pos_x, sprite_pos_y;
  logic               wall_active;
  logic [7:0]         clip_first, clip_last;
  logic [2:0]         wall_kind;

  // Header test pipeline
  logic               hdr_early_reject, hdr_need_cross;
  logic signed [15:0] hdr_sdx, hdr_sdy, hdr_dx, hdr_dy;
  logic signed [31:0] hdr_p1, hdr_p2;
  logic [7:0]         hdr_first, hdr_last;
  logic [2:0]         hdr_kind;

  logic accept;
  logic [31:0] d_sx, d_sy, d_px, d_py;
  logic miss, both_below, need_cross, col_hit, off_screen;

  assign req.ready = (state == F_IDLE) && !q_full;
  assign accept    = req.valid && req.ready;

  // Header classification terms, from the item and the sprite registers
  always_comb begin
    d_sx       = req.end_x - req.point_x;
    d_sy       = req.end_y - req.point_y;
    d_px       = sprite_pos_x - req.point_x;
    d_py       = sprite_pos_y - req.point_y;
    miss       = (req.first_x > sprite_last) || (req.last_x < sprite_first);
    both_below = (req.scale_a < sprite_scale) && (req.scale_b < sprite_scale);
    need_cross = (req.scale_a <= sprite_scale) || (req.scale_b <= sprite_scale);
    off_screen = {1'b0, req.first_x} >= 9'(SCREEN_WIDTH);
    col_hit    = wall_active && (req.first_x >= clip_first) &&
                 (req.first_x <= clip_last) && !off_screen;
  end

  // Command to the back end
  always_comb begin
    q_push              = 1'b0;
    q_cmd.op            = CMD_READ;
    q_cmd.first         = req.first_x;
    q_cmd.last          = req.last_x;
    q_cmd.kind          = wall_kind;
    q_cmd.tsil          = req.top_sil;
    q_cmd.bsil          = req.bottom_sil;
    q_cmd.force_default = off_screen;
    if (accept) begin
      case (req.opcode)
        OP_BEGIN: begin
          q_push   = 1'b1;
          q_cmd.op = CMD_CLEAR;
        end
        OP_COLUMN: begin
          q_push   = col_hit;
          q_cmd.op = CMD_CLIP;
        end
        OP_READ: begin
          q_push   = 1'b1;
          q_cmd.op = CMD_READ;
        end
        default: q_push = 1'b0;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: after a header the front passes a multiply state and a compare state for the cross-product test
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept && req.opcode == OP_HEADER) state_next = F_HDR_MUL;
      end
      F_HDR_MUL: state_next = F_HDR_CMP;
      F_HDR_CMP: state_next = F_IDLE;
      default:   state_next = F_IDLE;
    endcase
  end

  // Sprite and wall control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_first <= '0;
      sprite_last  <= '0;
      sprite_scale <= '0;
      sprite_pos_x <= '0;
      sprite_pos_y <= '0;
      wall_active  <= 1'b0;
      clip_first   <= '0;
      clip_last    <= '0;
      wall_kind    <= '0;
    end else begin
      if (accept && req.opcode == OP_BEGIN) begin
        sprite_first <= req.first_x;
        sprite_last  <= req.last_x;
        sprite_scale <= req.scale_a;
        sprite_pos_x <= req.point_x;
        sprite_pos_y <= req.point_y;
        wall_active  <= 1'b0;
      end
      if (state == F_HDR_CMP) begin
        if (hdr_early_reject || (hdr_need_cross && (hdr_p1 < hdr_p2))) begin
          wall_active <= 1'b0;
        end else begin
          wall_active <= 1'b1;
          clip_first  <= hdr_first;
          clip_last   <= hdr_last;
          wall_kind   <= hdr_kind;
        end
      end
    end
  end

  // Header datapath: capture terms, then multiply
  always_ff @(posedge clk) begin
    if (accept && req.opcode == OP_HEADER) begin
      hdr_early_reject <= miss || both_below || (req.sil_kind == 3'd0);
      hdr_need_cross   <= need_cross;
      hdr_sdx          <= signed'(d_sx[31:16]);
      hdr_sdy          <= signed'(d_sy[31:16]);
      hdr_dx           <= signed'(d_px[31:16]);
      hdr_dy           <= signed'(d_py[31:16]);
      hdr_first        <= (req.first_x < sprite_first) ? sprite_first : req.first_x;
      hdr_last         <= (req.last_x > sprite_last) ? sprite_last : req.last_x;
      hdr_kind         <= req.sil_kind;
    end
    if (state == F_HDR_MUL) begin
      hdr_p1 <= hdr_sdx * hdr_dy;
      hdr_p2 <= hdr_dx * hdr_sdy;
    end
  end

endmodule

`default_nettype wire

FILE: design/scsc_cmd_fifo.sv
// Short command queue between the front and back ends.
// Depends on scsc_pkg for cmd_t and the queue depth.
`default_nettype none

module scsc_cmd_fifo import scsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  cmd_t                entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]  wr_ptr, rd_ptr;
  logic [CMDQ_AW:0]    count;

  assign full  = count == (CMDQ_AW + 1)'(CMDQ_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

FILE: design/scsc_back.sv
// Back end: owns the opening store and carries out clear, clip and read commands.
// Depends on scsc_pkg and scsc_out_if.
`default_nettype none

module scsc_back import scsc_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 224
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  cmd_t       q_head,
  input  wire logic  q_empty,
  output logic       q_pop,
  scsc_out_if.source rsp
);

  localparam int unsigned AW = $clog2(SCREEN_WIDTH);
  localparam logic [7:0] OPEN_BOTTOM_DEFAULT = 8'(SCREEN_HEIGHT);

  back_state_t state, state_next;

  // Opening store: top in 15..8, bottom in 7..0; entries not valid read as reset value
  logic [15:0]             mem [SCREEN_WIDTH];
  logic [SCREEN_WIDTH-1:0] valid;
  logic [15:0]             rd_data;
  logic                    rd_valid;

  cmd_t        cur;
  logic [7:0]  out_top, out_bottom;
  logic        out_valid;

  logic        issue, do_clear, do_write, do_result;
  logic [7:0]  cur_top, cur_bot, new_top, new_bot;

  assign rsp.valid       = out_valid;
  assign rsp.open_top    = out_top;
  assign rsp.open_bottom = out_bottom;

  // Control: one command at a time, clip and read go through a store read and then an execute step
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    issue      = 1'b0;
    do_clear   = 1'b0;
    do_write   = 1'b0;
    do_result  = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.op == CMD_CLEAR) begin
            do_clear = 1'b1;
          end else begin
            issue      = 1'b1;
            state_next = B_EXEC;
          end
        end
      end
      B_EXEC: begin
        if (cur.op == CMD_CLIP) begin
          do_write   = 1'b1;
          state_next = B_IDLE;
        end else if (!out_valid || rsp.ready) begin
          do_result  = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Opening seen by the current command, and its clipped value
  always_comb begin
    if (rd_valid && !cur.force_default) begin
      cur_top = rd_data[15:8];
      cur_bot = rd_data[7:0];
    end else begin
      cur_top = OPEN_TOP_DEFAULT;
      cur_bot = OPEN_BOTTOM_DEFAULT;
    end
    new_top = cur_top;
    new_bot = cur_bot;
    case (cur.kind)
      KIND_SOLID: begin
        new_top = OPEN_BOTTOM_DEFAULT;
        new_bot = 8'h00;
      end
      KIND_BOTTOM: begin
        if (cur_bot == OPEN_BOTTOM_DEFAULT) new_bot = cur.bsil;
      end
      KIND_TOP: begin
        if (cur_top == OPEN_TOP_DEFAULT) new_top = cur.tsil;
      end
      KIND_BOTH: begin
        if (cur_bot == OPEN_BOTTOM_DEFAULT) new_bot = cur.bsil;
        if (cur_top == OPEN_TOP_DEFAULT) new_top = cur.tsil;
      end
      default: begin
        new_top = cur_top;
        new_bot = cur_bot;
      end
    endcase
  end

  // Store read and write ports
  always_ff @(posedge clk) begin
    if (do_write) mem[cur.first[AW-1:0]] <= {new_top, new_bot};
    if (issue)    rd_data <= mem[q_head.first[AW-1:0]];
  end

  // Command capture at issue
  always_ff @(posedge clk) begin
    if (issue) begin
      cur      <= q_head;
      rd_valid <= valid[q_head.first[AW-1:0]];
    end
  end

  // Valid bits: reset and begin clear, clip sets
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < SCREEN_WIDTH; i++) begin
        if (do_clear && (9'(i) >= {1'b0, q_head.first}) &&
            (9'(i) <= {1'b0, q_head.last})) begin
          valid[i] <= 1'b0;
        end
      end
      if (do_write) valid[cur.first[AW-1:0]] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_result) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_result) begin
      out_top    <= cur_top;
      out_bottom <= cur_bot;
    end
  end

endmodule

`default_nettype wire

FILE: design/scsc_checker.sv
// Port-level checker for the sprite column silhouette clip block, with its bind.
// Depends on scsc_pkg for opcodes.
`default_nettype none

module scsc_checker import scsc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic [1:0] req_opcode,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] rsp_open_top,
  input wire logic [7:0] rsp_open_bottom
);

  // A stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_open_top) && $stable(rsp_open_bottom))
    else $error("result payload changed while stalled");

  // A header transaction holds the front for the following cycle
  a_hdr_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_opcode == OP_HEADER |=> !req_ready)
    else $error("item taken during header test");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result offered after reset");

endmodule

bind sprite_column_silhouette_clip scsc_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_opcode      (req.opcode),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_open_top    (rsp.open_top),
  .rsp_open_bottom (rsp.open_bottom)
);

`default_nettype wire
